// ----- hw/rtl/assert_macros.svh -----
// shared assertion macros for the servo bus engine checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored during reset
`define SBPE_ASSERT_NOW(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// next-cycle implication, ignored during reset
`define SBPE_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/sbpe_pkg.sv -----
package sbpe_pkg;

  localparam int FRAME_MAX = 14;
  localparam int LEN_W     = 4;

  typedef logic [FRAME_MAX-1:0][7:0] frame_t;

  typedef enum logic [1:0] {
    CMD_PING       = 2'd0,
    CMD_WRITE_BYTE = 2'd1,
    CMD_WRITE_POS  = 2'd2,
    CMD_READ_POS   = 2'd3
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_HEADER   = 3'd1,
    ST_BAD_ID       = 3'd2,
    ST_BAD_CHECKSUM = 3'd3,
    ST_SERVO_ERROR  = 3'd4
  } status_t;

  localparam logic FUNC_COMMAND = 1'b0;
  localparam logic FUNC_REPLY   = 1'b1;

  localparam logic OUT_TX      = 1'b0;
  localparam logic OUT_VERDICT = 1'b1;

  // frame bytes
  localparam logic [7:0] HEADER_BYTE     = 8'hFF;
  localparam logic [7:0] INST_PING       = 8'h01;
  localparam logic [7:0] INST_READ       = 8'h02;
  localparam logic [7:0] INST_WRITE      = 8'h03;
  localparam logic [7:0] LEN_PING        = 8'h02;
  localparam logic [7:0] LEN_SHORT       = 8'h04;
  localparam logic [7:0] LEN_WRITE_POS   = 8'h0A;
  localparam logic [7:0] REG_GOAL_ACCEL  = 8'h29;
  localparam logic [7:0] REG_PRESENT_POS = 8'h38;
  localparam logic [7:0] READ_COUNT      = 8'h02;

  // frame lengths in bytes
  localparam logic [LEN_W-1:0] FLEN_PING      = 4'd6;
  localparam logic [LEN_W-1:0] FLEN_SHORT     = 4'd8;
  localparam logic [LEN_W-1:0] FLEN_WRITE_POS = 4'd14;

  // reply byte positions
  localparam logic [2:0] RIDX_ID        = 3'd2;
  localparam logic [2:0] RIDX_ERROR     = 3'd4;
  localparam logic [2:0] RIDX_POS_LOW   = 3'd5;
  localparam logic [2:0] RIDX_POS_HIGH  = 3'd6;
  localparam logic [2:0] RIDX_LAST_SHRT = 3'd5;
  localparam logic [2:0] RIDX_LAST_LONG = 3'd7;

  typedef struct packed {
    logic       valid;
    status_t    status;
    logic [15:0] position;
  } verdict_t;

endpackage

// ----- hw/rtl/sbpe_frame_build.sv -----
module sbpe_frame_build
  import sbpe_pkg::*;
(
  input  logic [1:0]       cmd_kind,
  input  logic [7:0]       servo_id,
  input  logic [7:0]       reg_address,
  input  logic [7:0]       reg_value,
  input  logic [15:0]      target_position,
  input  logic [15:0]      move_speed,
  input  logic [7:0]       move_accel,
  output frame_t           frame,
  output logic [LEN_W-1:0] frame_len
);

  frame_t     body;
  logic [7:0] sum;
  logic [LEN_W-1:0] ck_idx;

  always_comb begin
    body      = '0;
    body[0]   = HEADER_BYTE;
    body[1]   = HEADER_BYTE;
    body[2]   = servo_id;
    frame_len = FLEN_PING;
    unique case (cmd_kind_t'(cmd_kind))
      CMD_PING: begin
        body[3]   = LEN_PING;
        body[4]   = INST_PING;
        frame_len = FLEN_PING;
      end
      CMD_WRITE_BYTE: begin
        body[3]   = LEN_SHORT;
        body[4]   = INST_WRITE;
        body[5]   = reg_address;
        body[6]   = reg_value;
        frame_len = FLEN_SHORT;
      end
      CMD_WRITE_POS: begin
        body[3]   = LEN_WRITE_POS;
        body[4]   = INST_WRITE;
        body[5]   = REG_GOAL_ACCEL;
        body[6]   = move_accel;
        body[7]   = target_position[7:0];
        body[8]   = target_position[15:8];
        body[11]  = move_speed[7:0];
        body[12]  = move_speed[15:8];
        frame_len = FLEN_WRITE_POS;
      end
      CMD_READ_POS: begin
        body[3]   = LEN_SHORT;
        body[4]   = INST_READ;
        body[5]   = REG_PRESENT_POS;
        body[6]   = READ_COUNT;
        frame_len = FLEN_SHORT;
      end
    endcase
  end

  // unused bytes are zero, so summing the fixed span is safe; balanced tree
  assign sum = ((body[2] + body[3]) + (body[4] + body[5]))
             + ((body[6] + body[7]) + (body[8] + body[9]))
             + ((body[10] + body[11]) + body[12]);

  assign ck_idx = frame_len - LEN_W'(1);

  always_comb begin
    for (int i = 0; i < FRAME_MAX; i++) begin
      frame[i] = (LEN_W'(i) == ck_idx) ? ~sum : body[i];
    end
  end

endmodule

// ----- hw/rtl/sbpe_reply_check.sv -----
module sbpe_reply_check
  import sbpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_load,
  input  logic [1:0] cmd_kind,
  input  logic [7:0] servo_id,
  input  logic       reply_take,
  input  logic [7:0] rx_byte,
  output verdict_t   verdict
);

  logic       reply_armed;
  logic       reply_long;
  logic [7:0] reply_id;
  logic [2:0] byte_index;
  logic [7:0] sum_acc;
  logic       header_bad;
  logic       id_bad;
  logic       error_bad;
  logic [7:0] pos_low;
  logic [7:0] pos_high;

  logic    at_last;
  status_t status;

  assign at_last = byte_index == (reply_long ? RIDX_LAST_LONG : RIDX_LAST_SHRT);

  always_comb begin
    priority if (header_bad) begin
      status = ST_BAD_HEADER;
    end else if (id_bad) begin
      status = ST_BAD_ID;
    end else if (rx_byte != ~sum_acc) begin
      status = ST_BAD_CHECKSUM;
    end else if (error_bad) begin
      status = ST_SERVO_ERROR;
    end else begin
      status = ST_OK;
    end
  end

  assign verdict.valid    = reply_take && reply_armed && at_last;
  assign verdict.status   = status;
  assign verdict.position = (status == ST_OK && reply_long) ? {pos_high, pos_low} : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_armed <= 1'b0;
      reply_long  <= 1'b0;
      reply_id    <= '0;
      byte_index  <= '0;
      sum_acc     <= '0;
      header_bad  <= 1'b0;
      id_bad      <= 1'b0;
      error_bad   <= 1'b0;
      pos_low     <= '0;
      pos_high    <= '0;
    end else if (cmd_load) begin
      reply_armed <= cmd_kind_t'(cmd_kind) != CMD_WRITE_POS;
      reply_long  <= cmd_kind_t'(cmd_kind) == CMD_READ_POS;
      reply_id    <= servo_id;
      byte_index  <= '0;
      sum_acc     <= '0;
      header_bad  <= 1'b0;
      id_bad      <= 1'b0;
      error_bad   <= 1'b0;
      pos_low     <= '0;
      pos_high    <= '0;
    end else if (reply_take && reply_armed) begin
      if (at_last) begin
        reply_armed <= 1'b0;
        byte_index  <= '0;
      end else begin
        byte_index <= byte_index + 3'd1;
        if (byte_index < RIDX_ID) begin
          if (rx_byte != HEADER_BYTE) header_bad <= 1'b1;
        end else begin
          sum_acc <= sum_acc + rx_byte;
          if (byte_index == RIDX_ID)       id_bad    <= rx_byte != reply_id;
          if (byte_index == RIDX_ERROR)    error_bad <= rx_byte != 8'h00;
          if (byte_index == RIDX_POS_LOW)  pos_low   <= rx_byte;
          if (byte_index == RIDX_POS_HIGH) pos_high  <= rx_byte;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/servo_bus_packet_engine_core.sv -----
// Master for a half-duplex smart-servo bus. A command request (func 0) builds
// a whole frame and streams it out, one transmit byte per cycle unless the
// output stalls, through a frame shift register into a single output
// register: a ping is 6 bytes, a write byte or read position 8, a position
// write 14. The next request is taken in the same cycle the last frame byte
// moves to the output, so back-to-back commands keep the output busy every
// cycle. Reply bytes (func 1) feed the checker; the last byte of a 6-byte
// status reply, or of an 8-byte position reply, produces one verdict result.
// Checks are reported in order: header, id, checksum, servo error byte.
// Reply bytes while no reply is expected are dropped without a result. A new
// command abandons any pending reply; a position write expects none.
module servo_bus_packet_engine_core
  import sbpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [1:0]  cmd_kind,
  input  logic [7:0]  servo_id,
  input  logic [7:0]  reg_address,
  input  logic [7:0]  reg_value,
  input  logic [15:0] target_position,
  input  logic [15:0] move_speed,
  input  logic [7:0]  move_accel,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  tx_byte,
  output logic        frame_last,
  output logic [2:0]  status_code,
  output logic [15:0] position
);

  frame_t           frame;
  logic [LEN_W-1:0] frame_len;
  verdict_t         verdict;

  // pending results: frame bytes lowest first, or one verdict
  frame_t           frame_q;
  logic [LEN_W-1:0] left_q;
  logic             kind_q;
  status_t          status_q;
  logic [15:0]      pos_q;

  logic accept;
  logic push;
  logic last_push;

  // a result moves to the output register whenever the register frees up
  assign push      = (left_q != '0) && (!out_valid || !out_stall);
  assign last_push = push && (left_q == LEN_W'(1));
  // take the next request once the last pending result is on its way
  assign in_stall  = (left_q != '0) && !last_push;
  assign accept    = in_valid && !in_stall;

  sbpe_frame_build u_build (
    .cmd_kind        (cmd_kind),
    .servo_id        (servo_id),
    .reg_address     (reg_address),
    .reg_value       (reg_value),
    .target_position (target_position),
    .move_speed      (move_speed),
    .move_accel      (move_accel),
    .frame           (frame),
    .frame_len       (frame_len)
  );

  sbpe_reply_check u_check (
    .clk        (clk),
    .rst        (rst),
    .cmd_load   (accept && func == FUNC_COMMAND),
    .cmd_kind   (cmd_kind),
    .servo_id   (servo_id),
    .reply_take (accept && func == FUNC_REPLY),
    .rx_byte    (rx_byte),
    .verdict    (verdict)
  );

  // pending result control
  always_ff @(posedge clk) begin
    if (rst) begin
      left_q <= '0;
    end else if (accept && func == FUNC_COMMAND) begin
      left_q <= frame_len;
    end else if (accept && verdict.valid) begin
      left_q <= LEN_W'(1);
    end else if (push) begin
      left_q <= left_q - LEN_W'(1);
    end
  end

  // pending result payload
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_COMMAND) begin
      frame_q  <= frame;
      kind_q   <= OUT_TX;
      status_q <= ST_OK;
      pos_q    <= '0;
    end else if (accept && verdict.valid) begin
      frame_q  <= '0;
      kind_q   <= OUT_VERDICT;
      status_q <= verdict.status;
      pos_q    <= verdict.position;
    end else if (push) begin
      frame_q <= frame_t'(frame_q >> 8);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind    <= kind_q;
      tx_byte     <= (kind_q == OUT_TX) ? frame_q[0] : 8'h00;
      frame_last  <= left_q == LEN_W'(1);
      status_code <= status_q;
      position    <= pos_q;
    end
  end

endmodule

// ----- hw/rtl/sbpe_checker.sv -----
`include "assert_macros.svh"

module sbpe_checker
  import sbpe_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        func,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [7:0]  tx_byte,
  input logic        frame_last,
  input logic [2:0]  status_code,
  input logic [15:0] position
);

  // a verdict is always a one-result frame with no transmit data
  `SBPE_ASSERT_NOW(a_verdict_shape, clk, rst, out_valid && out_kind == OUT_VERDICT, frame_last && tx_byte == 8'h00)

  // transmit bytes carry no status or position
  `SBPE_ASSERT_NOW(a_tx_clean, clk, rst, out_valid && out_kind == OUT_TX, status_code == ST_OK && position == 16'd0)

  // position only on an ok verdict
  `SBPE_ASSERT_NOW(a_pos_ok_only, clk, rst, out_valid && position != 16'd0, out_kind == OUT_VERDICT && status_code == ST_OK)

  // every frame is several bytes long, so a command holds off the next request
  `SBPE_ASSERT_NEXT(a_cmd_busy, clk, rst, in_valid && !in_stall && func == FUNC_COMMAND, in_stall)

  // stalled result holds
  `SBPE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(tx_byte) && $stable(out_kind) && $stable(frame_last))

endmodule

bind servo_bus_packet_engine_core sbpe_checker u_sbpe_checker (.*);
